// ----- hw/rtl/epoch_seconds_to_calendar_date_top_macros.svh -----
// Assertion macros used by the checker file of the epoch-to-date block.
// Depends on: a clk_i clock and an active-low rst_ni reset in the using scope.
`ifndef EPOCH_SECONDS_TO_CALENDAR_DATE_TOP_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_DATE_TOP_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define EPCAL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies another one in the next cycle.
`define EPCAL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/epcal_pkg.sv -----
// Constants and small tables for the epoch-seconds to calendar-date converter.
// Depends on: nothing.
`default_nettype none

package epcal_pkg;

  localparam int unsigned STAMP_BITS_DEF = 40;

  // Divisors of the shared serial divider.
  localparam int unsigned SECS_PER_DAY   = 86400;
  localparam int unsigned SECS_PER_HOUR  = 3600;
  localparam int unsigned SECS_PER_MIN   = 60;
  localparam int unsigned DAYS_PER_ERA   = 146097;
  localparam int unsigned DAYS_PER_4Y    = 1460;
  localparam int unsigned DAYS_PER_100Y  = 36524;
  localparam int unsigned DAYS_PER_YEAR  = 365;
  localparam int unsigned YEARS_PER_ERA  = 400;

  // Days from 0000-03-01 to 1970-01-01 in the proleptic Gregorian calendar.
  localparam int unsigned DAYS_FROM_ZERO = 719468;

  // Remainder register width (largest divisor is below 2^18).
  localparam int unsigned REM_BITS = 18;
  // Dividend lengths of the narrow divisions.
  localparam int unsigned LEN_HMS  = 17;   // second of day
  localparam int unsigned LEN_MS   = 12;   // second of hour
  localparam int unsigned DOE_BITS = 18;   // day of era

  // Month index counted from March: index of January.
  localparam logic [3:0] MP_JAN = 4'd10;

  // First day of each March-based month within the year.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  // Whole centuries in a year of era (0..399).
  function automatic logic [1:0] cent_of(input logic [8:0] y);
    logic [1:0] c;
    if (y >= 9'd300) begin
      c = 2'd3;
    end else if (y >= 9'd200) begin
      c = 2'd2;
    end else if (y >= 9'd100) begin
      c = 2'd1;
    end else begin
      c = 2'd0;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/epoch_seconds_to_calendar_date_top.sv -----
// Epoch-seconds to Gregorian calendar date converter, one bit-serial divider.
// Depends on: epcal_pkg.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+----------------------------------------
//   command  | in        | start_i / busy_o   | epoch_seconds_i
//   result   | out       | done_o (strobe)    | cal_year_o cal_month_o cal_day_o
//            |           |                    | clock_hour_o clock_minute_o clock_second_o
//
// A beat enters at a rising edge with start_i high and busy_o low.
// One conversion keeps busy_o high while the shared restoring divider retires
// one quotient bit a cycle over seven constant divisions, followed by date
// assembly in the S_MUL, S_DOY and S_MON states.
// done_o pulses for one cycle as busy_o falls; the receiver cannot stall, and a
// new command may be taken in that same cycle.
// Reset clears the sequencer and the strobe; the data path needs none.
`default_nettype none

module epoch_seconds_to_calendar_date_top
  import epcal_pkg::*;
#(
  parameter int unsigned STAMP_BITS = STAMP_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [STAMP_BITS-1:0] epoch_seconds_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [15:0]                cal_year_o,
  output logic [3:0]                 cal_month_o,
  output logic [4:0]                 cal_day_o,
  output logic [4:0]                 clock_hour_o,
  output logic [5:0]                 clock_minute_o,
  output logic [5:0]                 clock_second_o
);

  localparam int unsigned W   = STAMP_BITS;
  localparam int unsigned CW  = $clog2(W + 1);
  // Days since the epoch stay below 2^(W-16).
  localparam int unsigned DW  = W - 16;
  // Days since 0000-03-01.
  localparam int unsigned ZW  = ((DW > 20) ? DW : 20) + 1;
  localparam int unsigned RW  = REM_BITS;

  localparam logic [ZW-1:0] Z_OFFSET = ZW'(DAYS_FROM_ZERO);
  localparam logic [DOE_BITS-1:0] DOE_LAST = DOE_BITS'(DAYS_PER_ERA - 1);

  // Sequencer: one state per division, then date assembly.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DAY  = 4'd1;   // seconds / 86400
  localparam logic [3:0] S_HOUR = 4'd2;   // second of day / 3600
  localparam logic [3:0] S_MIN  = 4'd3;   // second of hour / 60
  localparam logic [3:0] S_ERA  = 4'd4;   // shifted day / 146097
  localparam logic [3:0] S_C4   = 4'd5;   // day of era / 1460
  localparam logic [3:0] S_C100 = 4'd6;   // day of era / 36524
  localparam logic [3:0] S_YOE  = 4'd7;   // corrected day / 365
  localparam logic [3:0] S_MUL  = 4'd8;   // start of year within era
  localparam logic [3:0] S_DOY  = 4'd9;   // day of year
  localparam logic [3:0] S_MON  = 4'd10;  // month, day, year

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;

  // Divider: dividend bits leave at the top while quotient bits enter at the bottom.
  logic [W-1:0]  dvd_q, dvd_d;
  logic [RW-1:0] rem_q, rem_d;

  logic [DW-1:0]       days_q, days_d;
  logic [15:0]         era_q, era_d;
  logic [DOE_BITS-1:0] doe_q, doe_d;
  logic [6:0]          c4_q, c4_d;
  logic [8:0]          yoe_q, yoe_d;
  logic [DOE_BITS-1:0] cum_q, cum_d;
  logic [15:0]         ybase_q, ybase_d;
  logic [8:0]          doy_q, doy_d;

  logic [15:0] year_q, year_d;
  logic [3:0]  month_q, month_d;
  logic [4:0]  day_q, day_d;
  logic [4:0]  hour_q, hour_d;
  logic [5:0]  min_q, min_d;
  logic [5:0]  sec_q, sec_d;

  // One restoring step.
  logic [RW-1:0] divisor;
  logic [RW:0]   trial;
  logic [RW:0]   diff;
  logic          q_bit;
  logic [RW-1:0] rem_nx;
  logic [W-1:0]  dvd_nx;
  logic          div_last;

  logic [ZW-1:0]       z_val;
  logic [DOE_BITS-1:0] yn_val;
  logic [3:0]          mp;

  always_comb begin
    case (state_q)
      S_DAY:   divisor = RW'(SECS_PER_DAY);
      S_HOUR:  divisor = RW'(SECS_PER_HOUR);
      S_MIN:   divisor = RW'(SECS_PER_MIN);
      S_ERA:   divisor = RW'(DAYS_PER_ERA);
      S_C4:    divisor = RW'(DAYS_PER_4Y);
      S_C100:  divisor = RW'(DAYS_PER_100Y);
      S_YOE:   divisor = RW'(DAYS_PER_YEAR);
      default: divisor = RW'(SECS_PER_DAY);
    endcase
  end

  assign trial    = {rem_q, dvd_q[W-1]};
  assign diff     = trial - {1'b0, divisor};
  assign q_bit    = (trial >= {1'b0, divisor});
  assign rem_nx   = q_bit ? diff[RW-1:0] : trial[RW-1:0];
  assign dvd_nx   = {dvd_q[W-2:0], q_bit};
  assign div_last = (cnt_q == CW'(1));

  // Shift the day count to a March-based year so the leap day falls last.
  assign z_val = {{(ZW-DW){1'b0}}, days_q} + Z_OFFSET;

  // Day of era with leap days taken out, so that /365 gives the year of era.
  always_comb begin
    yn_val = doe_q - DOE_BITS'(c4_q) + DOE_BITS'(dvd_nx[2:0]);
    if (doe_q == DOE_LAST) begin
      yn_val = yn_val - DOE_BITS'(1);
    end
  end

  // Month from March: the month starts rise, so the last one passed wins.
  always_comb begin
    mp = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (doy_q >= month_start(4'(i))) begin
        mp = 4'(i);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    days_d  = days_q;
    era_d   = era_q;
    doe_d   = doe_q;
    c4_d    = c4_q;
    yoe_d   = yoe_q;
    cum_d   = cum_q;
    ybase_d = ybase_q;
    doy_d   = doy_q;
    year_d  = year_q;
    month_d = month_q;
    day_d   = day_q;
    hour_d  = hour_q;
    min_d   = min_q;
    sec_d   = sec_q;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          dvd_d   = epoch_seconds_i;
          rem_d   = '0;
          cnt_d   = CW'(W);
          state_d = S_DAY;
        end
      end

      S_DAY, S_HOUR, S_MIN, S_ERA, S_C4, S_C100, S_YOE: begin
        // Advance one quotient bit.
        dvd_d = dvd_nx;
        rem_d = rem_nx;
        cnt_d = cnt_q - CW'(1);
        if (div_last) begin
          // Load the next division if any, left-aligned so only its bits are walked.
          rem_d = '0;
          case (state_q)
            S_DAY: begin
              days_d  = dvd_nx[DW-1:0];
              dvd_d   = {rem_nx[LEN_HMS-1:0], {(W-LEN_HMS){1'b0}}};
              cnt_d   = CW'(LEN_HMS);
              state_d = S_HOUR;
            end
            S_HOUR: begin
              hour_d  = dvd_nx[4:0];
              dvd_d   = {rem_nx[LEN_MS-1:0], {(W-LEN_MS){1'b0}}};
              cnt_d   = CW'(LEN_MS);
              state_d = S_MIN;
            end
            S_MIN: begin
              min_d   = dvd_nx[5:0];
              sec_d   = rem_nx[5:0];
              dvd_d   = {z_val, {(W-ZW){1'b0}}};
              cnt_d   = CW'(ZW);
              state_d = S_ERA;
            end
            S_ERA: begin
              // Only the low 16 bits of the era count are kept, like the 16-bit year.
              era_d   = dvd_nx[15:0];
              doe_d   = rem_nx[DOE_BITS-1:0];
              dvd_d   = {rem_nx[DOE_BITS-1:0], {(W-DOE_BITS){1'b0}}};
              cnt_d   = CW'(DOE_BITS);
              state_d = S_C4;
            end
            S_C4: begin
              c4_d    = dvd_nx[6:0];
              dvd_d   = {doe_q, {(W-DOE_BITS){1'b0}}};
              cnt_d   = CW'(DOE_BITS);
              state_d = S_C100;
            end
            S_C100: begin
              dvd_d   = {yn_val, {(W-DOE_BITS){1'b0}}};
              cnt_d   = CW'(DOE_BITS);
              state_d = S_YOE;
            end
            S_YOE: begin
              yoe_d   = dvd_nx[8:0];
              state_d = S_MUL;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_MUL: begin
        cum_d   = DOE_BITS'(yoe_q) * DOE_BITS'(DAYS_PER_YEAR)
                + DOE_BITS'(yoe_q >> 2) - DOE_BITS'(cent_of(yoe_q));
        ybase_d = era_q * 16'(YEARS_PER_ERA) + 16'(yoe_q);
        state_d = S_DOY;
      end

      S_DOY: begin
        doy_d   = 9'(doe_q - cum_q);
        state_d = S_MON;
      end

      S_MON: begin
        // January and February belong to the next civil year.
        if (mp >= MP_JAN) begin
          month_d = mp - 4'd9;
          year_d  = ybase_q + 16'd1;
        end else begin
          month_d = mp + 4'd3;
          year_d  = ybase_q;
        end
        day_d   = 5'(doy_q - month_start(mp) + 9'd1);
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q   <= dvd_d;
    rem_q   <= rem_d;
    days_q  <= days_d;
    era_q   <= era_d;
    doe_q   <= doe_d;
    c4_q    <= c4_d;
    yoe_q   <= yoe_d;
    cum_q   <= cum_d;
    ybase_q <= ybase_d;
    doy_q   <= doy_d;
    year_q  <= year_d;
    month_q <= month_d;
    day_q   <= day_d;
    hour_q  <= hour_d;
    min_q   <= min_d;
    sec_q   <= sec_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign cal_year_o     = year_q;
  assign cal_month_o    = month_q;
  assign cal_day_o      = day_q;
  assign clock_hour_o   = hour_q;
  assign clock_minute_o = min_q;
  assign clock_second_o = sec_q;

endmodule

`default_nettype wire

// ----- hw/rtl/epcal_checker.sv -----
// Port-level checker for the epoch-to-date converter, bound to the top level.
// Depends on: epoch_seconds_to_calendar_date_top_macros.svh.
`default_nettype none
`include "epoch_seconds_to_calendar_date_top_macros.svh"

module epcal_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start_i,
  input wire logic       busy_i,
  input wire logic       done_i,
  input wire logic [3:0] cal_month_i,
  input wire logic [4:0] cal_day_i,
  input wire logic [4:0] clock_hour_i,
  input wire logic [5:0] clock_minute_i,
  input wire logic [5:0] clock_second_i
);

  // An accepted command beat must hold the converter busy.
  `EPCAL_ASSERT_NEXT(a_start_busy, start_i && !busy_i, busy_i, "command beat did not start work")
  // Every conversion ends with exactly one result beat.
  `EPCAL_ASSERT(a_end_done, $fell(busy_i) |-> done_i, "busy dropped without a result")
  `EPCAL_ASSERT(a_done_idle, done_i |-> !busy_i, "result strobe while still busy")
  `EPCAL_ASSERT_NEXT(a_done_once, done_i, !done_i, "result strobe longer than one cycle")
  `EPCAL_ASSERT(a_fields_ok,
    done_i |-> (cal_month_i >= 4'd1 && cal_month_i <= 4'd12 && cal_day_i >= 5'd1 &&
                clock_hour_i <= 5'd23 && clock_minute_i <= 6'd59 && clock_second_i <= 6'd59),
    "result field out of range")

endmodule

bind epoch_seconds_to_calendar_date_top epcal_checker u_epcal_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_i         (busy_o),
  .done_i         (done_o),
  .cal_month_i    (cal_month_o),
  .cal_day_i      (cal_day_o),
  .clock_hour_i   (clock_hour_o),
  .clock_minute_i (clock_minute_o),
  .clock_second_i (clock_second_o)
);

`default_nettype wire

// ----- tb/sv/epoch_seconds_to_calendar_date_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the epoch-seconds to calendar-date converter.
// Depends on: epcal_pkg and epoch_seconds_to_calendar_date_top (hw/rtl).

module epoch_seconds_to_calendar_date_top_tb;

  import epcal_pkg::*;

  localparam int unsigned STAMP_W = STAMP_BITS_DEF;

  // Largest whole day whose last second still fits in the 40-bit stamp.
  localparam longint unsigned LAST_FULL_DAY = 64'd12725828;

  // One converted date, laid out like the result ports.
  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } calendar_t;

  // One row of the directed table; typed rows carry a hand-written date.
  typedef struct {
    logic [STAMP_W-1:0] stamp;
    bit                 typed;
    calendar_t          want;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               start_i;
  logic [STAMP_W-1:0] epoch_seconds_i;
  logic               busy_o;
  logic               done_o;
  logic [15:0]        cal_year_o;
  logic [3:0]         cal_month_o;
  logic [4:0]         cal_day_o;
  logic [4:0]         clock_hour_o;
  logic [5:0]         clock_minute_o;
  logic [5:0]         clock_second_o;

  // Dates predicted for accepted beats, oldest first.
  calendar_t   pending_dates[$];
  stim_row_t   directed_rows[$];
  int unsigned mismatch_count = 0;

  epoch_seconds_to_calendar_date_top #(
    .STAMP_BITS(STAMP_W)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .epoch_seconds_i(epoch_seconds_i),
    .busy_o         (busy_o),
    .done_o         (done_o),
    .cal_year_o     (cal_year_o),
    .cal_month_o    (cal_month_o),
    .cal_day_o      (cal_day_o),
    .clock_hour_o   (clock_hour_o),
    .clock_minute_o (clock_minute_o),
    .clock_second_o (clock_second_o)
  );

  // 20 ns period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Full Gregorian rule: every fourth year, but not centuries unless divisible by 400.
  function automatic bit year_has_leap_day(input longint unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // Predict the date of one stamp. Strip whole 400-year cycles first so the
  // year walk stays under 400 steps, then walk the months.
  function automatic calendar_t stamp_to_calendar(input logic [STAMP_W-1:0] stamp);
    longint unsigned t;
    longint unsigned days;
    longint unsigned year;
    int unsigned     mon;
    int unsigned     mon_len;
    bit              found;
    calendar_t       c;
    t = stamp;
    c.second = 6'(t % 60);
    t = t / 60;
    c.minute = 6'(t % 60);
    t = t / 60;
    c.hour   = 5'(t % 24);
    days     = t / 24;
    year     = 1970 + (days / 146097) * 400;
    days     = days % 146097;
    while (days >= (year_has_leap_day(year) ? 366 : 365)) begin
      days = days - (year_has_leap_day(year) ? 366 : 365);
      year = year + 1;
    end
    mon   = 0;
    found = 1'b0;
    while (mon < 11 && !found) begin
      case (mon)
        1:          mon_len = year_has_leap_day(year) ? 29 : 28;
        3, 5, 8, 10: mon_len = 30;
        default:    mon_len = 31;
      endcase
      if (days < mon_len) begin
        found = 1'b1;
      end else begin
        days = days - mon_len;
        mon  = mon + 1;
      end
    end
    c.year  = 16'(year);
    c.month = 4'(mon + 1);
    c.day   = 5'(days + 1);
    return c;
  endfunction

  function automatic stim_row_t stamp_row(input logic [STAMP_W-1:0] stamp, input bit typed,
                                          input int y, input int mo, input int d,
                                          input int h, input int mi, input int s);
    stim_row_t r;
    r.stamp       = stamp;
    r.typed       = typed;
    r.want.year   = 16'(y);
    r.want.month  = 4'(mo);
    r.want.day    = 5'(d);
    r.want.hour   = 5'(h);
    r.want.minute = 6'(mi);
    r.want.second = 6'(s);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Send one beat. A nonzero gap lowers start_i and puts noise on the stamp for
  // the gap; with after_done the gap counts from the end of the conversion in
  // flight, otherwise from the previous acceptance. With no gap start_i stays
  // high through busy, so the beat lands on the done cycle.
  task automatic send_stamp(input logic [STAMP_W-1:0] stamp, input calendar_t want,
                            input int unsigned gap, input bit after_done);
    if (gap != 0) begin
      start_i         <= 1'b0;
      epoch_seconds_i <= STAMP_W'({$urandom, $urandom});
      if (after_done) begin
        while (busy_o) @(negedge clk_i);
      end
      repeat (gap) @(negedge clk_i);
    end
    start_i         <= 1'b1;
    epoch_seconds_i <= stamp;
    // busy_o only moves at rising edges, so its value here decides the next edge.
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
    // The done of the previous beat may be checked at this same edge; it pops
    // the oldest date, so the order against this push does not matter.
    pending_dates.push_back(want);
    @(negedge clk_i);
  endtask

  // Check every done strobe against the oldest predicted date.
  always @(posedge clk_i) begin
    calendar_t want;
    if (rst_ni && done_o) begin
      if (pending_dates.size() == 0) begin
        $display("%0t ns: result strobe with no beat outstanding", $time);
        mismatch_count++;
      end else begin
        want = pending_dates.pop_front();
        check_field("cal_year", want.year, cal_year_o);
        check_field("cal_month", 16'(want.month), 16'(cal_month_o));
        check_field("cal_day", 16'(want.day), 16'(cal_day_o));
        check_field("clock_hour", 16'(want.hour), 16'(clock_hour_o));
        check_field("clock_minute", 16'(want.minute), 16'(clock_minute_o));
        check_field("clock_second", 16'(want.second), 16'(clock_second_o));
      end
    end
  end

  initial begin
    stim_row_t          row;
    calendar_t          want;
    logic [STAMP_W-1:0] stamp;
    longint unsigned    day_no;
    longint unsigned    sec_of_day;
    int unsigned        gap;

    rst_ni          = 1'b0;
    start_i         = 1'b0;
    epoch_seconds_i = '0;

    // Epoch start, field extremes, month and year rollovers.
    directed_rows.push_back(stamp_row(40'd0, 1, 1970, 1, 1, 0, 0, 0));
    directed_rows.push_back(stamp_row(40'd59, 1, 1970, 1, 1, 0, 0, 59));
    directed_rows.push_back(stamp_row(40'd86399, 1, 1970, 1, 1, 23, 59, 59));
    directed_rows.push_back(stamp_row(40'd86400, 1, 1970, 1, 2, 0, 0, 0));
    directed_rows.push_back(stamp_row(40'd31535999, 1, 1970, 12, 31, 23, 59, 59));
    directed_rows.push_back(stamp_row(40'd31536000, 1, 1971, 1, 1, 0, 0, 0));
    // Leap days: plain leap year, multiple of 400, and a skipped century.
    directed_rows.push_back(stamp_row(40'd68169600, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(stamp_row(40'd951782400, 1, 2000, 2, 29, 0, 0, 0));
    directed_rows.push_back(stamp_row(40'd951868800, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(stamp_row(40'd4107542399, 1, 2100, 2, 28, 23, 59, 59));
    directed_rows.push_back(stamp_row(40'd4107542400, 1, 2100, 3, 1, 0, 0, 0));
    directed_rows.push_back(stamp_row(40'd13574563200, 1, 2400, 2, 29, 0, 0, 0));
    // Either side of one full 400-year cycle.
    directed_rows.push_back(stamp_row(40'd12622780799, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(stamp_row(40'd12622780800, 0, 0, 0, 0, 0, 0, 0));
    // 32-bit limits, the top bit, alternating bit patterns and the top of the stamp range.
    directed_rows.push_back(stamp_row(40'd2147483647, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(stamp_row(40'd4294967295, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(stamp_row(40'h80_0000_0000, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(stamp_row(40'hAA_AAAA_AAAA, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(stamp_row(40'h55_5555_5555, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(stamp_row(40'hFF_FFFF_FFFF, 0, 0, 0, 0, 0, 0, 0));

    // Hold reset, then release it away from the rising edge.
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Walk the directed table.
    foreach (directed_rows[i]) begin
      row  = directed_rows[i];
      want = row.typed ? row.want : stamp_to_calendar(row.stamp);
      send_stamp(row.stamp, want, $urandom_range(0, 10), 1'($urandom_range(0, 1)));
    end

    // Random beats: mix full-range stamps, 32-bit stamps, stamps hugging
    // midnight (to hit day, month and year rollovers) and stamps inside the
    // first 400-year cycle. Every fourth block of 128 runs back to back.
    for (int n = 0; n < 1100; n++) begin
      case ($urandom_range(0, 3))
        0: stamp = STAMP_W'({$urandom, $urandom});
        1: stamp = STAMP_W'($urandom);
        2: begin
          day_no     = $urandom_range(0, 32'(LAST_FULL_DAY));
          sec_of_day = $urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(86397, 86399);
          stamp      = STAMP_W'(day_no * 86400 + sec_of_day);
        end
        default: begin
          day_no = $urandom_range(0, 146096);
          stamp  = STAMP_W'(day_no * 86400 + $urandom_range(0, 86399));
        end
      endcase
      gap = ((n / 128) % 4 == 3) ? 0 : $urandom_range(0, 10);
      send_stamp(stamp, stamp_to_calendar(stamp), gap, 1'($urandom_range(0, 1)));
    end
    start_i <= 1'b0;

    // Drain the last conversion, then watch a full conversion time for strays.
    while (pending_dates.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("epoch_seconds_to_calendar_date_top_tb: PASS");
    end else begin
      $display("epoch_seconds_to_calendar_date_top_tb: FAIL");
    end
    $finish;
  end

  // Bail out if the block hangs; a correct run ends well under a quarter of this.
  initial begin
    #20_000_000;
    $display("epoch_seconds_to_calendar_date_top_tb: FAIL");
    $finish;
  end

endmodule
